// ===== hdl/lus_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lus_pkg: shared types and constants for the largest uniform square block
// Holds the field widths, the reset width of a grid row and the neighbor
// bundle that goes from the top level into the side calculator.
// ----------------------------------------------------------------------------
package lus_pkg;

    localparam int LUS_VALUE_W     = 8;
    localparam int LUS_SIDE_W      = 9;
    localparam int LUS_CFG_W       = 9;
    localparam int LUS_MAX_WIDTH   = 256;
    localparam int LUS_WIDTH_RESET = 256;

    typedef logic [LUS_VALUE_W-1:0] lus_value_t;
    typedef logic [LUS_SIDE_W-1:0]  lus_side_t;

    localparam lus_side_t LUS_SIDE_MAX = '1;

    // The three neighbors of the current cell: above, left and above-left.
    typedef struct packed {
        lus_side_t  up_side;
        lus_value_t up_value;
        lus_side_t  left_side;
        lus_value_t left_value;
        lus_side_t  diag_side;
        lus_value_t diag_value;
    } lus_nbr_t;

endpackage

// ===== hdl/lus_line_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lus_line_buf: line buffer for the previous grid row
// One synchronous memory of side and value per column, one write and one
// registered read per cycle, with a bypass when both hit the same column.
// ----------------------------------------------------------------------------
module lus_line_buf
    import lus_pkg::*;
#(
    parameter int DEPTH = LUS_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  lus_side_t     wr_side,
    input  lus_value_t    wr_value,
    output lus_side_t     rd_side,
    output lus_value_t    rd_value
);

    localparam int DW = LUS_SIDE_W + LUS_VALUE_W;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_side, wr_value};
        end
        if (rd_en) begin
            // A read of the column being written this cycle takes the new data.
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= {wr_side, wr_value};
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_side  = rd_data_reg[DW-1:LUS_VALUE_W];
    assign rd_value = rd_data_reg[LUS_VALUE_W-1:0];

endmodule

// ===== hdl/lus_side_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lus_side_calc: maximal-square recurrence for one cell
// The side is the smallest neighbor side plus one when all three neighbors
// hold the cell's value, and one otherwise; it saturates at the field maximum.
// ----------------------------------------------------------------------------
module lus_side_calc
    import lus_pkg::*;
(
    input  lus_nbr_t   nbr,
    input  lus_value_t cell_value,
    input  logic       first_col,
    input  logic       first_row,
    output lus_side_t  side
);

    lus_side_t min_ul;
    lus_side_t min_all;
    logic      match;

    always_comb begin
        min_ul  = (nbr.up_side < nbr.left_side) ? nbr.up_side : nbr.left_side;
        min_all = (min_ul < nbr.diag_side) ? min_ul : nbr.diag_side;
        match   = !first_row && !first_col
                  && (nbr.up_value == cell_value)
                  && (nbr.left_value == cell_value)
                  && (nbr.diag_value == cell_value);
        if (!match) begin
            side = lus_side_t'(1);
        end else if (min_all == LUS_SIDE_MAX) begin
            side = LUS_SIDE_MAX;
        end else begin
            side = min_all + lus_side_t'(1);
        end
    end

endmodule

// ===== hdl/largest_uniform_square_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_uniform_square_top: largest square of equal cells in a grid
// Streams a grid in raster order and reports the side of the largest square
// whose cells all hold the same value, one result per grid.
// ----------------------------------------------------------------------------
// Usage notes.
// The input channel (s_valid, s_ready) carries one cell per beat together with
// an end-of-frame flag that marks the last cell of the grid. The result
// channel (m_valid, m_ready) carries one beat per grid with the largest side.
// The row length comes from the row width register, written through cfg_wr_en
// and cfg_wr_data while the block is idle; a zero is taken as one and a value
// above MAX_WIDTH as MAX_WIDTH.
// Throughput is one cell per cycle. A cell's memory read is issued at its
// accept edge, and the cell writes the line buffer as it leaves the cell
// stage. An end-of-frame cell loads the output register at that same edge,
// so m_valid rises as that cell leaves the cell stage.
// The result sits in an output register, so cells keep flowing while it
// waits. Only an end-of-frame cell stalls, and only while an earlier result
// still sits unread; the input then drops s_ready until m_ready frees it.
// Reset sets the row width to 256 and starts a fresh grid. The line buffer
// needs no clearing pass: cells of the first row never look upward.
// ----------------------------------------------------------------------------
module largest_uniform_square_top
    import lus_pkg::*;
#(
    parameter int MAX_WIDTH = LUS_MAX_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [LUS_CFG_W-1:0] cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lus_value_t           s_cell_value,
    input  logic                 s_end_of_frame,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lus_side_t            m_largest_side
);

    // Column index width, and a width that can hold MAX_WIDTH itself.
    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > LUS_CFG_W) ? WW : LUS_CFG_W;

    // Configuration register.
    logic [LUS_CFG_W-1:0] row_width_reg;

    // Front of the pipeline: where the next accepted cell lands.
    logic [CW-1:0] column_count_reg, column_count_next;
    logic          first_row_reg, first_row_next;

    // Cell stage: the accepted cell waits here for its line buffer read.
    logic          s1_valid_reg, s1_valid_next;
    lus_value_t    s1_value_reg;
    logic          s1_eof_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_first_row_reg;

    // Neighbor state, updated as each cell leaves the cell stage.
    lus_side_t  left_side_reg, left_side_next;
    lus_value_t left_value_reg, left_value_next;
    lus_side_t  diag_side_reg, diag_side_next;
    lus_value_t diag_value_reg, diag_value_next;
    lus_side_t  best_side_reg, best_side_next;

    // Output register.
    logic      m_valid_reg, m_valid_next;
    lus_side_t m_side_reg, m_side_next;

    logic          accept;
    logic          s1_done;
    logic [WW-1:0] width_eff;
    logic [CMPW-1:0] width_ext;
    logic [WW-1:0] col_plus_one;
    lus_side_t     up_side;
    lus_value_t    up_value;
    lus_side_t     side;
    lus_side_t     best_new;
    lus_nbr_t      nbr;

    // The cell stage always finishes, except for an end-of-frame cell whose
    // result would land on an output register that is still full.
    assign s1_done = s1_valid_reg && (!s1_eof_reg || !m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_done;
    assign accept  = s_valid && s_ready;

    // Effective row width after clamping the register.
    always_comb begin
        width_ext = CMPW'(row_width_reg);
        if (row_width_reg == '0) begin
            width_eff = WW'(1);
        end else if (width_ext > CMPW'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(width_ext);
        end
        col_plus_one = WW'(column_count_reg) + WW'(1);
    end

    // Column position and first-row flag for the next cell.
    always_comb begin
        column_count_next = column_count_reg;
        first_row_next    = first_row_reg;
        if (accept) begin
            if (s_end_of_frame) begin
                column_count_next = '0;
                first_row_next    = 1'b1;
            end else if (col_plus_one >= width_eff) begin
                column_count_next = '0;
                first_row_next    = 1'b0;
            end else begin
                column_count_next = CW'(col_plus_one);
            end
        end
    end

    lus_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .aclk     (aclk),
        .rd_en    (accept),
        .rd_addr  (column_count_reg),
        .wr_en    (s1_done),
        .wr_addr  (s1_col_reg),
        .wr_side  (side),
        .wr_value (s1_value_reg),
        .rd_side  (up_side),
        .rd_value (up_value)
    );

    assign nbr = '{
        up_side:    up_side,
        up_value:   up_value,
        left_side:  left_side_reg,
        left_value: left_value_reg,
        diag_side:  diag_side_reg,
        diag_value: diag_value_reg
    };

    lus_side_calc u_side_calc (
        .nbr        (nbr),
        .cell_value (s1_value_reg),
        .first_col  (s1_col_reg == '0),
        .first_row  (s1_first_row_reg),
        .side       (side)
    );

    // Neighbor, running maximum and result updates as a cell completes.
    always_comb begin
        s1_valid_next   = s1_valid_reg;
        left_side_next  = left_side_reg;
        left_value_next = left_value_reg;
        diag_side_next  = diag_side_reg;
        diag_value_next = diag_value_reg;
        best_side_next  = best_side_reg;
        m_valid_next    = m_valid_reg;
        m_side_next     = m_side_reg;
        best_new        = (side > best_side_reg) ? side : best_side_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s1_done) begin
            s1_valid_next = 1'b0;
            if (s1_eof_reg) begin
                // Report this grid and start the next one from scratch.
                m_valid_next    = 1'b1;
                m_side_next     = best_new;
                left_side_next  = '0;
                left_value_next = '0;
                diag_side_next  = '0;
                diag_value_next = '0;
                best_side_next  = '0;
            end else begin
                left_side_next  = side;
                left_value_next = s1_value_reg;
                diag_side_next  = up_side;
                diag_value_next = up_value;
                best_side_next  = best_new;
            end
        end
        if (accept) begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg    <= LUS_CFG_W'(LUS_WIDTH_RESET);
            column_count_reg <= '0;
            first_row_reg    <= 1'b1;
            s1_valid_reg     <= 1'b0;
            left_side_reg    <= '0;
            left_value_reg   <= '0;
            diag_side_reg    <= '0;
            diag_value_reg   <= '0;
            best_side_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                row_width_reg <= cfg_wr_data;
            end
            column_count_reg <= column_count_next;
            first_row_reg    <= first_row_next;
            s1_valid_reg     <= s1_valid_next;
            left_side_reg    <= left_side_next;
            left_value_reg   <= left_value_next;
            diag_side_reg    <= diag_side_next;
            diag_value_reg   <= diag_value_next;
            best_side_reg    <= best_side_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_value_reg     <= s_cell_value;
            s1_eof_reg       <= s_end_of_frame;
            s1_col_reg       <= column_count_reg;
            s1_first_row_reg <= first_row_reg;
        end
        m_side_reg <= m_side_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_largest_side = m_side_reg;

`ifndef SYNTH
    // A held cell is always an end-of-frame cell blocked by a full output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_done) |-> (s1_eof_reg && m_valid_reg && !m_ready))
        else $error("cell stage stalled without a blocked result");

    // Every reported grid holds at least one cell, so the side is nonzero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_side_reg != '0))
        else $error("result side is zero");

    // An end-of-frame beat restarts the grid at the first column of a first row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_end_of_frame) |=> (column_count_reg == '0 && first_row_reg))
        else $error("grid position not cleared after end of frame");

    // A completed end-of-frame cell leaves a result and a cleared maximum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_done && s1_eof_reg) |=> (m_valid_reg && best_side_reg == '0))
        else $error("end of frame did not produce a result");
`endif

endmodule

// ===== sim/largest_uniform_square_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_uniform_square_checker: scoreboard for the uniform square block
// Watches the configuration port and both streams, keeps its own model of
// the side recurrence and line buffer, and compares every result beat with
// the oldest predicted largest side.
// ----------------------------------------------------------------------------
module largest_uniform_square_checker
    import lus_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [LUS_CFG_W-1:0] cfg_wr_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  lus_value_t           s_cell_value,
    input  logic                 s_end_of_frame,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  lus_side_t            m_largest_side,
    output int                   fail_count,
    output int                   pending_results
);

    logic [LUS_CFG_W-1:0] row_width;
    lus_side_t            above_side [LUS_MAX_WIDTH];
    lus_value_t           above_value[LUS_MAX_WIDTH];
    lus_side_t            left_side;
    lus_value_t           left_value;
    lus_side_t            diag_side;
    lus_value_t           diag_value;
    int                   column;
    bit                   in_first_row;
    lus_side_t            best_side;
    lus_side_t            expected_largest[$];
    lus_side_t            oldest;

    task automatic report_fault(input string msg);
        $display("%0t ns checker: %s", $time, msg);
        fail_count++;
    endtask

    task automatic clear_grid();
        left_side    = '0;
        left_value   = '0;
        diag_side    = '0;
        diag_value   = '0;
        column       = 0;
        in_first_row = 1'b1;
        best_side    = '0;
    endtask

    // Applies one accepted cell to the side recurrence; an end-of-frame cell
    // queues the grid's largest side and starts a fresh grid.
    task automatic predict_cell(input lus_value_t value, input logic last);
        int         width;
        int         col;
        int         side;
        lus_side_t  up_side;
        lus_value_t up_value;
        width = (row_width == 0) ? 1 :
                (row_width > LUS_MAX_WIDTH) ? LUS_MAX_WIDTH : int'(row_width);
        col = column;
        up_side  = above_side[col];
        up_value = above_value[col];

        side = 1;
        if (!in_first_row && col > 0 && up_value == value && left_value == value &&
            diag_value == value) begin
            side = int'(up_side);
            if (int'(left_side) < side) side = int'(left_side);
            if (int'(diag_side) < side) side = int'(diag_side);
            side = side + 1;
            if (side > int'(LUS_SIDE_MAX)) side = int'(LUS_SIDE_MAX);
        end

        diag_side        = up_side;
        diag_value       = up_value;
        above_side[col]  = lus_side_t'(side);
        above_value[col] = value;
        left_side        = lus_side_t'(side);
        left_value       = value;
        if (side > int'(best_side)) best_side = lus_side_t'(side);

        if (col + 1 >= width) begin
            column       = 0;
            in_first_row = 1'b0;
        end else begin
            column = col + 1;
        end

        if (last) begin
            expected_largest.push_back(best_side);
            clear_grid();
        end
    endtask

    initial begin
        fail_count      = 0;
        pending_results = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            row_width = LUS_CFG_W'(LUS_WIDTH_RESET);
            foreach (above_side[i]) begin
                above_side[i]  = '0;
                above_value[i] = '0;
            end
            clear_grid();
            expected_largest.delete();
        end else begin
            if (cfg_wr_en) row_width = cfg_wr_data;
            // Results leave before the cell of this edge is applied: a result
            // can never belong to a cell taken at the same edge.
            if (m_valid && m_ready) begin
                if (expected_largest.size() == 0) begin
                    report_fault($sformatf("result beat with nothing predicted, side %0d",
                                           m_largest_side));
                end else begin
                    oldest = expected_largest.pop_front();
                    if (m_largest_side !== oldest)
                        report_fault($sformatf("largest_side %0d, predicted %0d",
                                               m_largest_side, oldest));
                end
            end
            if (s_valid && s_ready) predict_cell(s_cell_value, s_end_of_frame);
        end
        pending_results = expected_largest.size();
    end

endmodule

// ===== sim/largest_uniform_square_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_uniform_square_top_tb: regression for the uniform square block
// Streams directed and random grids through the block at changing row
// widths, idles both streams in random bursts and forces back-pressure,
// while a checker module predicts and compares every result beat.
// ----------------------------------------------------------------------------
module largest_uniform_square_top_tb;
    import lus_pkg::*;

    // Stimulus volume. The random part stops once both counts are reached.
    localparam int ITEMS       = 800;
    localparam int MIN_FRAMES  = 40;
    // The last stretch of cells runs with no idling on either side.
    localparam int QUIET_TAIL  = 120;
    // The long receiver hold-off starts once this many cells went in.
    localparam int HOLD_AT     = 200;
    localparam int LONG_HOLD   = 300;
    // The block writes its line buffer as a taken cell leaves its cell stage, so
    // a quiet stretch makes sure that write is done before the width changes.
    localparam int SETTLE      = 4;
    localparam int TIMEOUT_NS  = 5_000_000;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [LUS_CFG_W-1:0] cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    lus_value_t           s_cell_value;
    logic                 s_end_of_frame;
    logic                 m_valid;
    logic                 m_ready;
    lus_side_t            m_largest_side;

    int fail_count;
    int pending_results;

    // Shared between the stimulus and the result sink. Each variable has a
    // single writer: the sink owns holding and long_hold_done.
    int cells_sent     = 0;
    int frames_sent    = 0;
    int cur_eff        = LUS_WIDTH_RESET;
    int gap_pct        = 15;
    bit quiet          = 1'b0;
    bit holding        = 1'b0;
    bit long_hold_done = 1'b0;

    largest_uniform_square_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cell_value   (s_cell_value),
        .s_end_of_frame (s_end_of_frame),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_largest_side (m_largest_side)
    );

    largest_uniform_square_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cell_value    (s_cell_value),
        .s_end_of_frame  (s_end_of_frame),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_largest_side  (m_largest_side),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offers one cell and returns at the rising edge that takes it. Inputs
    // only change at falling edges. Valid stays high between back-to-back
    // beats; a gap lowers it once and then raises it again.
    task automatic send_cell(input lus_value_t value, input logic last);
        int gap;
        @(negedge aclk);
        if (!quiet && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 7);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_cell_value   <= value;
        s_end_of_frame <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cells_sent++;
    endtask

    // Stops the input, waits until every predicted result has been read and
    // the block has settled, then writes the row width. The sender's pause
    // here doubles as the pause that drains the block completely.
    task automatic idle_then_config(input logic [LUS_CFG_W-1:0] value);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_eff = (value == 0) ? 1 :
                  (value > LUS_MAX_WIDTH) ? LUS_MAX_WIDTH : int'(value);
    endtask

    // One random grid at the width in force. Most grids are whole rows of
    // mostly one value so that real squares form; some end in the middle of
    // a row, some are pure noise, and some shrink the width mid-grid. A width
    // is only ever grown at a grid boundary, where the first row never looks
    // upward, so no unwritten line buffer entry is ever read. With wrap_row
    // the grid runs one to eight cells past one row at the top width, which
    // walks the column counter through its last entry and back to zero.
    task automatic run_frame(input bit wrap_row);
        int         w;
        int         total;
        int         rows;
        int         kind;
        int         shrink_at;
        int         npal;
        lus_value_t pal[3];
        lus_value_t value;
        w    = cur_eff;
        kind = $urandom_range(0, 9);
        npal = $urandom_range(1, 3);
        foreach (pal[i]) pal[i] = lus_value_t'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: gap_pct = 0;
            1: gap_pct = 10;
            2: gap_pct = 30;
            default: gap_pct = 15;
        endcase

        if (wrap_row) begin
            total = w + $urandom_range(1, 8);
            npal  = 1;
        end else if (w > 16) begin
            // Wide rows get short grids of up to twenty cells, mostly inside the first row.
            total = $urandom_range(1, 20);
        end else begin
            rows  = $urandom_range(1, 48 / w);
            total = rows * w;
            if (kind == 0) total = $urandom_range(1, total + w - 1);
        end
        shrink_at = (kind == 1 && total > 1 && !wrap_row) ?
                    $urandom_range(1, total - 1) : -1;

        for (int i = 0; i < total; i++) begin
            // A narrower width mid-grid only cuts rows short; every column the
            // next row reads was written by the row before it.
            if (i == shrink_at && !holding && !quiet)
                idle_then_config(LUS_CFG_W'($urandom_range(0, cur_eff)));
            if (kind == 2 && !wrap_row)
                value = lus_value_t'($urandom_range(0, 255));
            else if ($urandom_range(0, 9) < 7)
                value = pal[0];
            else
                value = pal[$urandom_range(0, npal - 1)];
            send_cell(value, i == total - 1);
        end
        frames_sent++;
    endtask

    // Result sink. It alternates ready runs with short stalls, and once, at a
    // set point of the run, holds off for a long stretch while the sender
    // keeps going, so that a second end-of-frame beat backs up behind an
    // unread result and the block drops s_ready.
    initial begin : result_sink
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (!long_hold_done && cells_sent >= HOLD_AT) begin
                long_hold_done = 1'b1;
                holding        = 1'b1;
                stall_left     = LONG_HOLD;
            end else if (stall_left == 0 && run_left == 0) begin
                if (!quiet && $urandom_range(0, 2) == 0)
                    stall_left = $urandom_range(1, 7);
                else
                    run_left = $urandom_range(1, 30);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                holding = 1'b0;
                if (run_left > 0) run_left--;
            end
        end
    end

    initial begin : stimulus
        logic [LUS_CFG_W-1:0] new_width;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_cell_value   = '0;
        s_end_of_frame = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. A one-cell grid at the reset width, ending in its
        // first row.
        send_cell(8'h00, 1'b1);

        // Two by two of one value gives a side of two; one odd cell in the
        // corner brings it back to one.
        idle_then_config(9'd2);
        for (int i = 0; i < 4; i++) send_cell(8'hFF, i == 3);
        for (int i = 0; i < 4; i++) send_cell((i == 3) ? 8'h01 : 8'h80, i == 3);

        // A width of zero is taken as one: every cell sits in the first
        // column and stays at side one.
        idle_then_config(9'd0);
        for (int i = 0; i < 3; i++) send_cell(8'h55, i == 2);

        // Three wide, ending two cells into the third row.
        idle_then_config(9'd3);
        for (int i = 0; i < 8; i++) send_cell(8'hAA, i == 7);

        // An all-ones width is clipped to the largest row; short grid.
        idle_then_config(9'h1FF);
        send_cell(8'hFF, 1'b0);
        send_cell(8'h00, 1'b1);

        // The width drops below the current column in the middle of a row,
        // so that row ends at the very next cell.
        idle_then_config(9'd4);
        send_cell(8'h33, 1'b0);
        send_cell(8'h33, 1'b0);
        idle_then_config(9'd2);
        send_cell(8'h33, 1'b0);
        send_cell(8'h33, 1'b0);
        send_cell(8'h33, 1'b1);

        // Random part, opened by one grid that wraps past the widest row.
        idle_then_config(9'd256);
        run_frame(1'b1);
        while (cells_sent < ITEMS || frames_sent < MIN_FRAMES) begin
            quiet = (cells_sent >= ITEMS - QUIET_TAIL);
            // Width changes at grid boundaries may grow or shrink the row;
            // none starts while the sink is in its long hold-off or once the
            // run has reached its quiet tail.
            if (!holding && !quiet && $urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 9))
                    0: new_width = 9'd0;
                    1: new_width = 9'd1;
                    2: new_width = 9'd256;
                    3: new_width = 9'd255;
                    4: new_width = LUS_CFG_W'($urandom_range(257, 511));
                    default: new_width = LUS_CFG_W'($urandom_range(2, 12));
                endcase
                idle_then_config(new_width);
            end
            run_frame(1'b0);
        end

        // Drain: wait for every predicted result, then idle on to catch any stray beat.
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lus_pkg.sv
hdl/lus_line_buf.sv
hdl/lus_side_calc.sv
hdl/largest_uniform_square_top.sv
sim/largest_uniform_square_checker.sv
sim/largest_uniform_square_top_tb.sv
